@@ rtl/dfm_pkg.sv @@
// Shared types and constants for the debounced fault monitor.
// Used by dfm_lane, dfm_out_stage and debounced_fault_monitor_unit; no dependencies.
package dfm_pkg;

   // Default widths handed to the top-level parameters.
   localparam int SAMPLE_WIDTH_DEF = 16;
   localparam int COUNT_WIDTH_DEF  = 16;

   // Fixed register field widths.
   localparam int LEVEL_W = 16;   // signed trip/recovery levels and count thresholds
   localparam int OC_W    = 15;   // unsigned overcurrent level
   localparam int DATA_W  = 32;   // CSR data width
   localparam int ADDR_W  = 5;    // byte address of the seven registers
   localparam int NUM_CH  = 5;

   // Fault channel positions in the flag vector.
   localparam int CH_OV  = 0;
   localparam int CH_UV  = 1;
   localparam int CH_BOT = 2;
   localparam int CH_MOT = 3;
   localparam int CH_OC  = 4;

   // Item codes.
   localparam logic ACT_FAST = 1'b0;
   localparam logic ACT_SLOW = 1'b1;

   // Register indexes (paddr[4:2]).
   typedef enum logic [2:0] {
      REG_BUS_OV   = 3'd0,
      REG_BUS_UV   = 3'd1,
      REG_BOARD_OT = 3'd2,
      REG_MOTOR_OT = 3'd3,
      REG_OC_LIMIT = 3'd4,
      REG_FAST_CNT = 3'd5,
      REG_SLOW_CNT = 3'd6
   } reg_idx_type;

   localparam logic [DATA_W-1:0] BUS_OV_RST   = 32'h7FFF_7FFF;
   localparam logic [DATA_W-1:0] BUS_UV_RST   = 32'h8000_8000;
   localparam logic [DATA_W-1:0] BOARD_OT_RST = 32'h7FFF_7FFF;
   localparam logic [DATA_W-1:0] MOTOR_OT_RST = 32'h7FFF_7FFF;
   localparam logic [OC_W-1:0]   OC_LIMIT_RST = 15'h7FFF;
   localparam logic [DATA_W-1:0] FAST_CNT_RST = 32'h0003_0003;
   localparam logic [DATA_W-1:0] SLOW_CNT_RST = 32'h0003_0003;

   // Per-lane decision for one beat.
   typedef struct packed {
      logic hit;          // this beat updates the lane
      logic excursion;    // sample beyond the trip level
      logic recovering;   // sample beyond the recovery level
   } lane_ctl_type;

endpackage

@@ rtl/dfm_lane.sv @@
// One debounce lane: trip counter, recovery counter and latched fault bit.
// Depends on dfm_pkg.
module dfm_lane #(
   parameter int COUNT_WIDTH = dfm_pkg::COUNT_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  dfm_pkg::lane_ctl_type        ctl,
   input  logic [dfm_pkg::LEVEL_W-1:0]  trip_n,
   input  logic [dfm_pkg::LEVEL_W-1:0]  rec_n,
   output logic                         flag_next
);

   localparam int THR_W = (COUNT_WIDTH > dfm_pkg::LEVEL_W) ? COUNT_WIDTH : dfm_pkg::LEVEL_W;

   logic [COUNT_WIDTH-1:0] trip_ff, trip_in, rec_ff, rec_in;
   logic [COUNT_WIDTH-1:0] trip_inc, rec_inc;
   logic                   flag_ff, flag_in;

   // Saturating increments.
   assign trip_inc = (&trip_ff) ? trip_ff : trip_ff + 1'b1;
   assign rec_inc  = (&rec_ff)  ? rec_ff  : rec_ff + 1'b1;

   always_comb begin
      trip_in = trip_ff;
      rec_in  = rec_ff;
      flag_in = flag_ff;
      if (ctl.hit && ctl.excursion) begin
         trip_in = trip_inc;
         rec_in  = '0;
         if (THR_W'(trip_inc) >= THR_W'(trip_n)) begin
            flag_in = 1'b1;
         end
      end else if (ctl.hit && ctl.recovering) begin
         if (flag_ff) begin
            rec_in = rec_inc;
            if (THR_W'(rec_inc) >= THR_W'(rec_n)) begin
               flag_in = 1'b0;
               trip_in = '0;
            end
         end else begin
            trip_in = '0;
         end
      end
   end

   assign flag_next = flag_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         trip_ff <= '0;
         rec_ff  <= '0;
         flag_ff <= 1'b0;
      end else begin
         trip_ff <= trip_in;
         rec_ff  <= rec_in;
         flag_ff <= flag_in;
      end
   end

   // A fault is only raised by an excursion beat and only cleared by a recovery beat.
   a_rise_on_excursion: assert property (@(posedge clock) disable iff (reset)
      $rose(flag_ff) |-> $past(ctl.hit && ctl.excursion))
      else $error("fault latched without an excursion");

   a_fall_on_recovery: assert property (@(posedge clock) disable iff (reset)
      $fell(flag_ff) |-> $past(ctl.hit && ctl.recovering))
      else $error("fault cleared without a recovery sample");

   a_fall_clears_trip: assert property (@(posedge clock) disable iff (reset)
      $fell(flag_ff) |-> (trip_ff == '0))
      else $error("trip counter not cleared with the fault");

endmodule

@@ rtl/dfm_out_stage.sv @@
// Merging output stage: gathers the lane flags into a result register with a skid entry.
// Depends on dfm_pkg.
module dfm_out_stage (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  logic [dfm_pkg::NUM_CH-1:0]  flags_next,
   output logic                        in_stall,
   output logic                        out_valid,
   input  logic                        out_stall,
   output logic [dfm_pkg::NUM_CH-1:0]  out_flags
);

   logic                        out_valid_ff, out_valid_in;
   logic                        skid_valid_ff, skid_valid_in;
   logic [dfm_pkg::NUM_CH-1:0]  out_flags_ff, out_flags_in;
   logic [dfm_pkg::NUM_CH-1:0]  skid_flags_ff, skid_flags_in;
   logic                        taken;

   assign taken = out_valid_ff && !out_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_flags_in  = out_flags_ff;
      skid_valid_in = skid_valid_ff;
      skid_flags_in = skid_flags_ff;
      if (!out_valid_ff || taken) begin
         // The input side is stalled whenever the skid entry is full.
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_flags_in  = skid_flags_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = accept;
            if (accept) begin
               out_flags_in = flags_next;
            end
         end
      end else if (accept) begin
         skid_valid_in = 1'b1;
         skid_flags_in = flags_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_flags_ff  <= out_flags_in;
      skid_flags_ff <= skid_flags_in;
   end

   assign in_stall  = skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_flags = out_flags_ff;

   // The skid entry only fills behind a waiting result and never takes a beat while full.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry holds a beat with no result in front of it");

   a_no_accept_when_full: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> !accept)
      else $error("beat accepted while the skid entry is full");

endmodule

@@ rtl/debounced_fault_monitor_unit.sv @@
// Top level of the debounced fault monitor: CSR block, five debounce lanes, output stage.
// Depends on dfm_pkg, dfm_lane and dfm_out_stage.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-------------------------------------------
//   req     | in        | req_valid/req_stall| action, bus_voltage, pcb_temp,
//           |           |                    | winding_temp, phase_amps
//   rsp     | out       | rsp_valid/rsp_stall| fault_flags, enable_allowed
//   csr     | in/out    | psel/penable/pready| paddr, pwrite, pwdata, prdata
//
// One beat is taken every cycle while req_stall is low. Each lane compares its sample and
// updates its counters in the cycle the beat is accepted, and the result is captured in
// the output register (or the skid entry while rsp is stalled) and driven onto rsp from there.
// Reset is synchronous and active high; it clears all counters and lane flags and
// loads the registers with their default levels and counts.
// When rsp is stalled, one more beat is absorbed by a skid entry; only then
// does req_stall rise, and it falls once the waiting result has been taken.
module debounced_fault_monitor_unit #(
   parameter int SAMPLE_WIDTH = dfm_pkg::SAMPLE_WIDTH_DEF,
   parameter int COUNT_WIDTH  = dfm_pkg::COUNT_WIDTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,

   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_action,
   input  logic signed [SAMPLE_WIDTH-1:0]     req_bus_voltage,
   input  logic signed [SAMPLE_WIDTH-1:0]     req_pcb_temp,
   input  logic signed [SAMPLE_WIDTH-1:0]     req_winding_temp,
   input  logic signed [SAMPLE_WIDTH-1:0]     req_phase_amps,

   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [dfm_pkg::NUM_CH-1:0]         rsp_fault_flags,
   output logic                               rsp_enable_allowed,

   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [dfm_pkg::ADDR_W-1:0]         paddr,
   input  logic [dfm_pkg::DATA_W-1:0]         pwdata,
   output logic [dfm_pkg::DATA_W-1:0]         prdata,
   output logic                               pready
);

   // Compare width covers both the sample and the 16-bit signed levels.
   localparam int CMP_W = (SAMPLE_WIDTH > dfm_pkg::LEVEL_W) ? SAMPLE_WIDTH : dfm_pkg::LEVEL_W;
   // Magnitude width covers both the saturated magnitude and the overcurrent level.
   localparam int MAG_W = ((SAMPLE_WIDTH - 1) > dfm_pkg::OC_W) ? (SAMPLE_WIDTH - 1)
                                                                : dfm_pkg::OC_W;
   localparam int LW = dfm_pkg::LEVEL_W;

   // ---------------------------------------------------------------------------
   // Configuration registers. Writes land on the access phase; pready is tied high.
   // ---------------------------------------------------------------------------
   logic [dfm_pkg::DATA_W-1:0] bus_ov_ff, bus_uv_ff, board_ot_ff, motor_ot_ff;
   logic [dfm_pkg::DATA_W-1:0] fast_cnt_ff, slow_cnt_ff;
   logic [dfm_pkg::OC_W-1:0]   oc_limit_ff;
   logic                       csr_write;
   dfm_pkg::reg_idx_type       csr_idx;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_idx   = dfm_pkg::reg_idx_type'(paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         bus_ov_ff   <= dfm_pkg::BUS_OV_RST;
         bus_uv_ff   <= dfm_pkg::BUS_UV_RST;
         board_ot_ff <= dfm_pkg::BOARD_OT_RST;
         motor_ot_ff <= dfm_pkg::MOTOR_OT_RST;
         oc_limit_ff <= dfm_pkg::OC_LIMIT_RST;
         fast_cnt_ff <= dfm_pkg::FAST_CNT_RST;
         slow_cnt_ff <= dfm_pkg::SLOW_CNT_RST;
      end else if (csr_write) begin
         case (csr_idx)
            dfm_pkg::REG_BUS_OV:   bus_ov_ff   <= pwdata;
            dfm_pkg::REG_BUS_UV:   bus_uv_ff   <= pwdata;
            dfm_pkg::REG_BOARD_OT: board_ot_ff <= pwdata;
            dfm_pkg::REG_MOTOR_OT: motor_ot_ff <= pwdata;
            dfm_pkg::REG_OC_LIMIT: oc_limit_ff <= pwdata[dfm_pkg::OC_W-1:0];
            dfm_pkg::REG_FAST_CNT: fast_cnt_ff <= pwdata;
            dfm_pkg::REG_SLOW_CNT: slow_cnt_ff <= pwdata;
            default: ;   // addresses past the last register are ignored
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         dfm_pkg::REG_BUS_OV:   prdata = bus_ov_ff;
         dfm_pkg::REG_BUS_UV:   prdata = bus_uv_ff;
         dfm_pkg::REG_BOARD_OT: prdata = board_ot_ff;
         dfm_pkg::REG_MOTOR_OT: prdata = motor_ot_ff;
         dfm_pkg::REG_OC_LIMIT: prdata = dfm_pkg::DATA_W'(oc_limit_ff);
         dfm_pkg::REG_FAST_CNT: prdata = fast_cnt_ff;
         dfm_pkg::REG_SLOW_CNT: prdata = slow_cnt_ff;
         default:               prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------------
   // Sample compares. All levels are signed 16-bit values; samples are widened
   // with sign extension so both sides compare at the same width.
   // ---------------------------------------------------------------------------
   logic accept, fast_beat, slow_beat;

   assign accept    = req_valid && !req_stall;
   assign fast_beat = accept && (req_action == dfm_pkg::ACT_FAST);
   assign slow_beat = accept && (req_action == dfm_pkg::ACT_SLOW);

   logic signed [CMP_W-1:0] bus_v, board_t, motor_t;
   logic signed [CMP_W-1:0] ov_trip, ov_rec, uv_trip, uv_rec;
   logic signed [CMP_W-1:0] bot_trip, bot_rec, mot_trip, mot_rec;

   assign bus_v    = CMP_W'(req_bus_voltage);
   assign board_t  = CMP_W'(req_pcb_temp);
   assign motor_t  = CMP_W'(req_winding_temp);
   assign ov_trip  = CMP_W'($signed(bus_ov_ff[2*LW-1:LW]));
   assign ov_rec   = CMP_W'($signed(bus_ov_ff[LW-1:0]));
   assign uv_trip  = CMP_W'($signed(bus_uv_ff[2*LW-1:LW]));
   assign uv_rec   = CMP_W'($signed(bus_uv_ff[LW-1:0]));
   assign bot_trip = CMP_W'($signed(board_ot_ff[2*LW-1:LW]));
   assign bot_rec  = CMP_W'($signed(board_ot_ff[LW-1:0]));
   assign mot_trip = CMP_W'($signed(motor_ot_ff[2*LW-1:LW]));
   assign mot_rec  = CMP_W'($signed(motor_ot_ff[LW-1:0]));

   // Phase current magnitude. The most negative code has no positive twin, so it
   // saturates to the largest positive value.
   logic [SAMPLE_WIDTH-1:0] cur_neg;
   logic [SAMPLE_WIDTH-2:0] cur_mag;
   logic                    oc_hit;

   assign cur_neg = ~req_phase_amps + 1'b1;

   always_comb begin
      if (!req_phase_amps[SAMPLE_WIDTH-1]) begin
         cur_mag = req_phase_amps[SAMPLE_WIDTH-2:0];
      end else if (cur_neg[SAMPLE_WIDTH-1]) begin
         cur_mag = '1;
      end else begin
         cur_mag = cur_neg[SAMPLE_WIDTH-2:0];
      end
   end

   assign oc_hit = MAG_W'(cur_mag) > MAG_W'(oc_limit_ff);

   // Lane decisions. Undervoltage trips below its trip level and recovers above its recovery level.
   dfm_pkg::lane_ctl_type        ctl [dfm_pkg::NUM_CH];
   logic [LW-1:0]                trip_n [dfm_pkg::NUM_CH];
   logic [LW-1:0]                rec_n  [dfm_pkg::NUM_CH];
   logic [dfm_pkg::NUM_CH-1:0]   flags_next;

   always_comb begin
      ctl[dfm_pkg::CH_OV]  = '{hit: fast_beat, excursion: bus_v > ov_trip,
                               recovering: bus_v < ov_rec};
      ctl[dfm_pkg::CH_UV]  = '{hit: fast_beat, excursion: bus_v < uv_trip,
                               recovering: bus_v > uv_rec};
      ctl[dfm_pkg::CH_BOT] = '{hit: slow_beat, excursion: board_t > bot_trip,
                               recovering: board_t < bot_rec};
      ctl[dfm_pkg::CH_MOT] = '{hit: slow_beat, excursion: motor_t > mot_trip,
                               recovering: motor_t < mot_rec};
      // Overcurrent has no separate recovery level: any in-range sample recovers.
      ctl[dfm_pkg::CH_OC]  = '{hit: slow_beat, excursion: oc_hit, recovering: !oc_hit};

      trip_n[dfm_pkg::CH_OV]  = fast_cnt_ff[2*LW-1:LW];
      rec_n[dfm_pkg::CH_OV]   = fast_cnt_ff[LW-1:0];
      trip_n[dfm_pkg::CH_UV]  = fast_cnt_ff[2*LW-1:LW];
      rec_n[dfm_pkg::CH_UV]   = fast_cnt_ff[LW-1:0];
      trip_n[dfm_pkg::CH_BOT] = slow_cnt_ff[2*LW-1:LW];
      rec_n[dfm_pkg::CH_BOT]  = slow_cnt_ff[LW-1:0];
      trip_n[dfm_pkg::CH_MOT] = slow_cnt_ff[2*LW-1:LW];
      rec_n[dfm_pkg::CH_MOT]  = slow_cnt_ff[LW-1:0];
      trip_n[dfm_pkg::CH_OC]  = fast_cnt_ff[2*LW-1:LW];
      rec_n[dfm_pkg::CH_OC]   = fast_cnt_ff[LW-1:0];
   end

   // Five independent debounce lanes, all updated in the cycle of acceptance.
   for (genvar g = 0; g < dfm_pkg::NUM_CH; g++) begin : g_lane
      dfm_lane #(
         .COUNT_WIDTH (COUNT_WIDTH)
      ) u_lane (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl[g]),
         .trip_n    (trip_n[g]),
         .rec_n     (rec_n[g]),
         .flag_next (flags_next[g])
      );
   end

   // Output register plus skid entry.
   dfm_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .flags_next (flags_next),
      .in_stall   (req_stall),
      .out_valid  (rsp_valid),
      .out_stall  (rsp_stall),
      .out_flags  (rsp_fault_flags)
   );

   assign rsp_enable_allowed = ~|rsp_fault_flags;

endmodule
